### hdl/dxt3_pkg.sv
// Shared types, constants and helper functions for the DXT3 block decoder.
// No dependencies; used by dxt3_palette and dxt3_block_decoder.
`timescale 1ns / 1ps

package dxt3_pkg;

  localparam int unsigned PixelsPerBlock = 16;
  localparam int unsigned PixIdxW        = $clog2(PixelsPerBlock);
  localparam logic [PixIdxW-1:0] LastPix = PixIdxW'(PixelsPerBlock - 1);

  // floor(x / 3) equals (x * 683) >> 11 for every x below 2048.
  localparam logic [9:0] Div3Mul   = 10'd683;
  localparam int unsigned Div3Shift = 11;

  // Channel order inside an RGB triple.
  localparam int unsigned ChRed   = 0;
  localparam int unsigned ChGreen = 1;
  localparam int unsigned ChBlue  = 2;

  typedef logic [2:0][7:0] rgb_t;
  typedef logic [3:0][2:0][7:0] pal_t;
  typedef logic [2:0][9:0] rgb_sum_t;

  // Per-pixel data that rides along with the palette.
  typedef struct packed {
    logic [63:0] alpha_bits;
    logic [31:0] color_indexes;
  } blk_t;

  function automatic logic [7:0] widen5(input logic [4:0] v);
    return {v, v[4:2]};
  endfunction

  function automatic logic [7:0] widen6(input logic [5:0] v);
    return {v, v[5:4]};
  endfunction

  function automatic rgb_t unpack565(input logic [15:0] c);
    rgb_t rgb;
    rgb[ChRed]   = widen5(c[15:11]);
    rgb[ChGreen] = widen6(c[10:5]);
    rgb[ChBlue]  = widen5(c[4:0]);
    return rgb;
  endfunction

  function automatic logic [7:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * 20'(Div3Mul);
    return 8'(prod >> Div3Shift);
  endfunction

endpackage

### hdl/dxt3_palette.sv
// Two-stage palette pipeline: endpoint expansion and weighted sums, then
// the divide by three. Depends on dxt3_pkg.
`timescale 1ns / 1ps

module dxt3_palette (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [15:0]         endpoint_a,
  input  logic [15:0]         endpoint_b,
  input  dxt3_pkg::blk_t      in_blk,
  output logic                out_valid,
  input  logic                out_ready,
  output dxt3_pkg::pal_t      out_pal,
  output dxt3_pkg::blk_t      out_blk
);
  import dxt3_pkg::*;

  logic     s1_valid_r, s1_valid_nxt;
  rgb_t     s1_ep_a_r, s1_ep_b_r;
  rgb_sum_t s1_sum2a_r, s1_sum2b_r;
  blk_t     s1_blk_r;

  logic     s2_valid_r, s2_valid_nxt;
  pal_t     s2_pal_r;
  blk_t     s2_blk_r;

  logic     s1_adv, s2_adv;
  rgb_t     ep_a, ep_b;
  rgb_sum_t sum2a, sum2b;
  pal_t     pal;

  assign s2_adv   = !s2_valid_r || out_ready;
  assign s1_adv   = !s1_valid_r || s2_adv;
  assign in_ready = s1_adv;

  assign s1_valid_nxt = s1_adv ? in_valid : s1_valid_r;
  assign s2_valid_nxt = s2_adv ? s1_valid_r : s2_valid_r;

  always_comb begin
    ep_a = unpack565(endpoint_a);
    ep_b = unpack565(endpoint_b);
    for (int ch = 0; ch < 3; ch++) begin
      sum2a[ch] = {1'b0, ep_a[ch], 1'b0} + 10'(ep_b[ch]);
      sum2b[ch] = 10'(ep_a[ch]) + {1'b0, ep_b[ch], 1'b0};
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      pal[0][ch] = s1_ep_a_r[ch];
      pal[1][ch] = s1_ep_b_r[ch];
      pal[2][ch] = div3(s1_sum2a_r[ch]);
      pal[3][ch] = div3(s1_sum2b_r[ch]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      s2_valid_r <= s2_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_ep_a_r  <= ep_a;
      s1_ep_b_r  <= ep_b;
      s1_sum2a_r <= sum2a;
      s1_sum2b_r <= sum2b;
      s1_blk_r   <= in_blk;
    end
    if (s2_adv) begin
      s2_pal_r <= pal;
      s2_blk_r <= s1_blk_r;
    end
  end

  assign out_valid = s2_valid_r;
  assign out_pal   = s2_pal_r;
  assign out_blk   = s2_blk_r;

endmodule

### hdl/dxt3_block_decoder.sv
// DXT3 (BC2) block decoder top level: palette pipeline, pixel serializer
// and output register. Depends on dxt3_pkg and dxt3_palette.
`timescale 1ns / 1ps
//
//  Channel  Handshake            Payload
//  in_      in_valid/in_ready    alpha_bits, endpoint_a, endpoint_b, color_indexes
//  out_     out_valid/out_ready  red, green, blue, alpha, pixel_index, last_pixel
//
// Each block yields 16 pixels, one per cycle while out_ready does not stall;
// the serializer takes the next block with the last pixel of the current
// one, so it is not ready for a new block before then. The edge that
// accepts the block loads the first palette stage; the second palette stage,
// the serializer and the output register follow in that order.
// Reset clears only the valid bits and the pixel counter.
// A stall on out_ready holds every stage that holds data.

module dxt3_block_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_alpha_bits,
  input  logic [15:0] in_endpoint_a,
  input  logic [15:0] in_endpoint_b,
  input  logic [31:0] in_color_indexes,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  output logic [3:0]  out_pixel_index,
  output logic        out_last_pixel
);
  import dxt3_pkg::*;

  blk_t               in_blk;
  logic               pal_valid, pal_ready;
  pal_t               pal_data;
  blk_t               pal_blk;

  logic               ser_valid_r, ser_valid_nxt;
  logic [PixIdxW-1:0] ser_cnt_r, ser_cnt_nxt;
  pal_t               ser_pal_r;
  blk_t               ser_blk_r, ser_blk_nxt;

  logic               out_valid_r;
  rgb_t               out_rgb_r;
  logic [7:0]         out_alpha_r;
  logic [PixIdxW-1:0] out_idx_r;
  logic               out_last_r;

  logic               out_adv, ser_emit, ser_take;
  logic [1:0]         sel;
  logic [3:0]         nib;

  assign in_blk = '{alpha_bits: in_alpha_bits, color_indexes: in_color_indexes};

  dxt3_palette u_palette (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .endpoint_a (in_endpoint_a),
    .endpoint_b (in_endpoint_b),
    .in_blk     (in_blk),
    .out_valid  (pal_valid),
    .out_ready  (pal_ready),
    .out_pal    (pal_data),
    .out_blk    (pal_blk)
  );

  assign out_adv   = !out_valid_r || out_ready;
  assign ser_emit  = ser_valid_r && out_adv;
  // The serializer takes the next block when empty or on its last pixel.
  assign pal_ready = !ser_valid_r || (ser_emit && ser_cnt_r == LastPix);
  assign ser_take  = pal_valid && pal_ready;

  // The current pixel always sits in the low bits; fields shift down per item.
  assign sel = ser_blk_r.color_indexes[1:0];
  assign nib = ser_blk_r.alpha_bits[3:0];

  always_comb begin
    ser_valid_nxt = ser_valid_r;
    ser_cnt_nxt   = ser_cnt_r;
    ser_blk_nxt   = ser_blk_r;
    if (ser_emit) begin
      ser_cnt_nxt               = ser_cnt_r + 1'b1;
      ser_blk_nxt.alpha_bits    = ser_blk_r.alpha_bits >> 4;
      ser_blk_nxt.color_indexes = ser_blk_r.color_indexes >> 2;
      if (ser_cnt_r == LastPix) begin
        ser_valid_nxt = 1'b0;
      end
    end
    if (ser_take) begin
      ser_valid_nxt = 1'b1;
      ser_cnt_nxt   = '0;
      ser_blk_nxt   = pal_blk;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_valid_r <= 1'b0;
      ser_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ser_valid_r <= ser_valid_nxt;
      ser_cnt_r   <= ser_cnt_nxt;
      if (out_adv) begin
        out_valid_r <= ser_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    ser_blk_r <= ser_blk_nxt;
    if (ser_take) begin
      ser_pal_r <= pal_data;
    end
    if (ser_emit) begin
      out_rgb_r   <= ser_pal_r[sel];
      out_alpha_r <= {nib, nib};
      out_idx_r   <= ser_cnt_r;
      out_last_r  <= (ser_cnt_r == LastPix);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_red         = out_rgb_r[ChRed];
  assign out_green       = out_rgb_r[ChGreen];
  assign out_blue        = out_rgb_r[ChBlue];
  assign out_alpha       = out_alpha_r;
  assign out_pixel_index = out_idx_r;
  assign out_last_pixel  = out_last_r;

  // Pixels of one block leave in raster order without gaps in the index.
  a_pixel_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last_pixel) |=>
      (out_valid && out_pixel_index == 4'($past(out_pixel_index) + 4'd1)))
    else $error("pixel index did not advance by one within a block");

  // A block part-way through the serializer always has a pixel on the output.
  a_mid_block_out: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_valid_r && ser_cnt_r != '0) |-> out_valid_r)
    else $error("serializer mid-block with an empty output register");

  // A freshly loaded block starts at its first pixel.
  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    ser_take |=> (ser_valid_r && ser_cnt_r == '0))
    else $error("serializer did not restart at pixel zero");

endmodule

### verif/dxt3_block_decoder_tb.sv
// Self-checking testbench for dxt3_block_decoder: feeds DXT3 blocks and checks every
// decoded RGBA pixel against a palette predictor built into the bench.
// Depends on hdl/dxt3_pkg.sv and hdl/dxt3_block_decoder.sv.
`timescale 1ns / 1ps

module dxt3_block_decoder_tb;
  import dxt3_pkg::*;

  typedef enum int {PH_SLOW_RX, PH_SLOW_TX, PH_FULL} phase_t;

  typedef struct {
    logic [63:0] alpha_bits;
    logic [15:0] endpoint_a;
    logic [15:0] endpoint_b;
    logic [31:0] color_indexes;
    phase_t      phase;
    bit          drain_first;
  } block_item_t;

  typedef struct {
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [7:0]         alpha;
    logic [PixIdxW-1:0] pixel_index;
    logic               last_pixel;
  } pixel_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] in_alpha_bits = '0;
  logic [15:0] in_endpoint_a = '0;
  logic [15:0] in_endpoint_b = '0;
  logic [31:0] in_color_indexes = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red;
  logic [7:0]  out_green;
  logic [7:0]  out_blue;
  logic [7:0]  out_alpha;
  logic [3:0]  out_pixel_index;
  logic        out_last_pixel;

  block_item_t block_q[$];
  pixel_t      pixel_q[$];
  phase_t      phase = PH_SLOW_RX;
  int          pixels_due = 0;
  int          blocks_taken = 0;
  int          fail_cnt = 0;
  int          rx_hold_cycles = 0;
  bit          rx_hold_done = 1'b0;

  dxt3_block_decoder u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_alpha_bits    (in_alpha_bits),
    .in_endpoint_a    (in_endpoint_a),
    .in_endpoint_b    (in_endpoint_b),
    .in_color_indexes (in_color_indexes),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue),
    .out_alpha        (out_alpha),
    .out_pixel_index  (out_pixel_index),
    .out_last_pixel   (out_last_pixel)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int tx_idle_pct(phase_t ph);
    case (ph)
      PH_SLOW_RX: return 23;
      PH_SLOW_TX: return 88;
      default:    return 0;
    endcase
  endfunction

  function automatic int rx_idle_pct(phase_t ph);
    case (ph)
      PH_SLOW_RX: return 88;
      PH_SLOW_TX: return 23;
      default:    return 0;
    endcase
  endfunction

  // Widens both 565 endpoints to three 8-bit channels and appends the block's 16 pixels.
  task automatic expand_block(input logic [63:0] alphas, input logic [15:0] ca,
                              input logic [15:0] cb, input logic [31:0] sel_bits);
    int unsigned lo[3];
    int unsigned hi[3];
    int unsigned palette[4][3];
    int unsigned v;
    int unsigned sel;
    int unsigned nib;
    pixel_t      px;
    v = 32'(ca[15:11]); lo[0] = ((v << 3) | (v >> 2)) & 8'hFF;
    v = 32'(ca[10:5]);  lo[1] = ((v << 2) | (v >> 4)) & 8'hFF;
    v = 32'(ca[4:0]);   lo[2] = ((v << 3) | (v >> 2)) & 8'hFF;
    v = 32'(cb[15:11]); hi[0] = ((v << 3) | (v >> 2)) & 8'hFF;
    v = 32'(cb[10:5]);  hi[1] = ((v << 2) | (v >> 4)) & 8'hFF;
    v = 32'(cb[4:0]);   hi[2] = ((v << 3) | (v >> 2)) & 8'hFF;
    for (int ch = 0; ch < 3; ch++) begin
      palette[0][ch] = lo[ch];
      palette[1][ch] = hi[ch];
      palette[2][ch] = (2 * lo[ch] + hi[ch]) / 3;
      palette[3][ch] = (lo[ch] + 2 * hi[ch]) / 3;
    end
    for (int p = 0; p < PixelsPerBlock; p++) begin
      sel = (sel_bits >> (2 * p)) & 32'h3;
      nib = 32'((alphas >> (4 * p)) & 64'hF);
      px.red         = 8'(palette[sel][0]);
      px.green       = 8'(palette[sel][1]);
      px.blue        = 8'(palette[sel][2]);
      px.alpha       = 8'((nib << 4) | nib);
      px.pixel_index = PixIdxW'(p);
      px.last_pixel  = (p == PixelsPerBlock - 1);
      pixel_q.push_back(px);
    end
  endtask

  // Sender: offers the next queued block, idling at the current phase's rate.
  always @(posedge clk) begin : drive
    bit          offer;
    block_item_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      offer = 1'b0;
      if (block_q.size() != 0) begin
        // A block accepted at this very edge is not yet counted in pixels_due.
        if (block_q[0].drain_first && (in_valid || pixels_due != 0)) begin
          offer = 1'b0;
        end else begin
          offer = ($urandom_range(99) >= tx_idle_pct(phase));
        end
      end
      if (offer) begin
        nxt = block_q.pop_front();
        in_alpha_bits    <= nxt.alpha_bits;
        in_endpoint_a    <= nxt.endpoint_a;
        in_endpoint_b    <= nxt.endpoint_b;
        in_color_indexes <= nxt.color_indexes;
        phase            <= nxt.phase;
      end
      in_valid <= offer;
    end
  end

  // Long receiver hold-off once the run is well into full-rate traffic.
  always @(posedge clk) begin
    if (!rst_n) begin
      rx_hold_cycles <= 0;
      rx_hold_done   <= 1'b0;
    end else if (!rx_hold_done && phase == PH_FULL && blocks_taken >= 300) begin
      rx_hold_cycles <= 400;
      rx_hold_done   <= 1'b1;
    end else if (rx_hold_cycles != 0) begin
      rx_hold_cycles <= rx_hold_cycles - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= (rx_hold_cycles == 0) && ($urandom_range(99) >= rx_idle_pct(phase));
    end
  end

  // Monitor: predicts on every accepted block and checks every accepted pixel.
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (pixel_q.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10) begin
            $display("ERROR: unexpected pixel %0d rgba=%h_%h_%h_%h", out_pixel_index,
                     out_red, out_green, out_blue, out_alpha);
          end
        end else begin
          want = pixel_q.pop_front();
          if (out_red !== want.red || out_green !== want.green || out_blue !== want.blue ||
              out_alpha !== want.alpha || out_pixel_index !== want.pixel_index ||
              out_last_pixel !== want.last_pixel) begin
            fail_cnt++;
            if (fail_cnt <= 10) begin
              $display("ERROR: pixel mismatch exp idx=%0d last=%b rgba=%h_%h_%h_%h",
                       want.pixel_index, want.last_pixel, want.red, want.green,
                       want.blue, want.alpha);
              $display("       got idx=%0d last=%b rgba=%h_%h_%h_%h", out_pixel_index,
                       out_last_pixel, out_red, out_green, out_blue, out_alpha);
            end
          end
        end
      end
      if (in_valid && in_ready) begin
        expand_block(in_alpha_bits, in_endpoint_a, in_endpoint_b, in_color_indexes);
        blocks_taken <= blocks_taken + 1;
      end
      pixels_due <= pixel_q.size();
    end
  end

  task automatic add_block(input logic [63:0] alphas, input logic [15:0] ca,
                           input logic [15:0] cb, input logic [31:0] sel_bits,
                           input phase_t ph, input bit drain);
    block_item_t it;
    it.alpha_bits    = alphas;
    it.endpoint_a    = ca;
    it.endpoint_b    = cb;
    it.color_indexes = sel_bits;
    it.phase         = ph;
    it.drain_first   = drain;
    block_q.push_back(it);
  endtask

  function automatic logic [15:0] pick_endpoint();
    case ($urandom_range(5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(16'hFFFF));
    endcase
  endfunction

  initial begin : stimulus
    logic [15:0] ca;
    logic [15:0] cb;
    logic [31:0] sel_bits;
    phase_t      ph;
    // Directed blocks: field extremes, every palette entry, equal endpoints,
    // endpoint_a not above endpoint_b, and single-channel endpoints.
    add_block(64'h0, 16'h0000, 16'h0000, 32'h0, PH_SLOW_RX, 1'b0);
    add_block(64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, PH_SLOW_RX, 1'b0);
    add_block(64'h0123_4567_89AB_CDEF, 16'hFFFF, 16'h0000, 32'h0000_0000, PH_SLOW_RX, 1'b0);
    add_block(64'hFEDC_BA98_7654_3210, 16'hFFFF, 16'h0000, 32'h5555_5555, PH_SLOW_RX, 1'b0);
    add_block(64'hF0F0_F0F0_0F0F_0F0F, 16'hFFFF, 16'h0000, 32'hAAAA_AAAA, PH_SLOW_RX, 1'b0);
    add_block(64'h5A5A_A5A5_5A5A_A5A5, 16'hFFFF, 16'h0000, 32'hFFFF_FFFF, PH_SLOW_RX, 1'b0);
    add_block(64'h1111_2222_3333_4444, 16'h0000, 16'hFFFF, 32'hE4E4_E4E4, PH_SLOW_RX, 1'b0);
    add_block(64'h8888_7777_6666_5555, 16'h1234, 16'h1234, 32'hE4E4_E4E4, PH_SLOW_RX, 1'b0);
    add_block(64'hFFFF_0000_FFFF_0000, 16'hF800, 16'h07E0, 32'h1B1B_1B1B, PH_SLOW_RX, 1'b0);
    add_block(64'h0000_FFFF_0000_FFFF, 16'h001F, 16'hF800, 32'hE4E4_E4E4, PH_SLOW_RX, 1'b0);
    add_block(64'hC3C3_3C3C_C3C3_3C3C, 16'h07E0, 16'h001F, 32'h9C9C_6363, PH_SLOW_RX, 1'b0);
    add_block(64'h1, 16'h0821, 16'hF7DE, 32'h0000_0001, PH_SLOW_RX, 1'b0);
    add_block(64'h8000_0000_0000_0000, 16'hF7DE, 16'h0821, 32'h8000_0000, PH_SLOW_RX, 1'b0);
    add_block(64'hDEAD_BEEF_CAFE_F00D, 16'h0001, 16'h0002, 32'h0123_4567, PH_SLOW_RX, 1'b0);
    add_block(64'h7FFF_FFFF_FFFF_FFFE, 16'h8410, 16'h7BEF, 32'h89AB_CDEF, PH_SLOW_RX, 1'b0);

    for (int n = 0; n < 370; n++) begin
      ph = (n < 120) ? PH_SLOW_RX : (n < 240) ? PH_SLOW_TX : PH_FULL;
      ca = pick_endpoint();
      cb = ($urandom_range(7) == 0) ? ca : pick_endpoint();
      case ($urandom_range(9))
        0:       sel_bits = 32'h0;
        1:       sel_bits = 32'hFFFF_FFFF;
        default: sel_bits = $urandom;
      endcase
      // Each phase starts only after the previous one has fully drained;
      // one extra drain point sits in the middle of the full-rate phase.
      add_block({$urandom, $urandom}, ca, cb, sel_bits, ph,
                (n == 120) || (n == 240) || (n == 330));
    end

    while (rst_n == 1'b0) @(posedge clk);
    while (block_q.size() != 0 || in_valid || pixels_due != 0 || pixel_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (20) @(posedge clk);
    if (fail_cnt == 0 && pixel_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule
